// File: hdl/swm_pkg.sv
// Shared widths and the neighbor flag bundle of the sliding-window median filter.
package swm_pkg;

   localparam int SAMPLE_W     = 32;
   localparam int CSR_W        = 7;
   localparam int MAX_WINDOW_D = 64;
   localparam int RESET_WINDOW = 3;

   // What a cell tells its neighbors about itself.
   typedef struct packed {
      logic valid;   // cell holds a window sample
      logic gt;      // empty, or its sample orders above the incoming one
   } flags_type;

endpackage

// File: hdl/sliding_window_median.sv
// Top level of the sliding-window median filter: cell chain, fill control and output register.
//
// Sliding-window median filter. Each accepted req word carries one signed 32-bit
// sample. The block keeps the last window_size samples in a chain of MAX_WINDOW
// cells held in ascending signed order; every cell also tracks the age of its
// sample, so the sample leaving the window is found by age and no arrival ring
// is needed. A step updates the whole chain at once: the leaving sample is
// dropped and the new one is slotted in, each cell choosing between itself, its
// two neighbors and the new sample. The chain takes one sample per clock while
// req_tready is high. While the window is filling no rsp word is produced; after
// that every sample yields one rsp word with the lower median, element
// (window_size-1)/2 of the sorted window. Once the step is registered in pend_ff
// and the output register is free, the median is picked out of the chain into
// the rsp output register, which drives rsp_tvalid; req_tready drops only while
// a median waits in the chain and the output register is still held by a
// stalled rsp word. A csr write (window_size, 0 acts as 1, above MAX_WINDOW acts
// as MAX_WINDOW) empties the window; write it only while the block is idle.
module sliding_window_median #(
   parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_D
) (
   input  logic                          clock,
   input  logic                          reset,
   // config register
   input  logic                          csr_we,
   input  logic [swm_pkg::CSR_W-1:0]     csr_wdata,      // [6:0] window_size
   // sample stream in
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [swm_pkg::SAMPLE_W-1:0]  req_tdata,      // [31:0] sample
   // median stream out
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [swm_pkg::SAMPLE_W-1:0]  rsp_tdata       // [31:0] median
);

   localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WW    = $clog2(MAX_WINDOW + 1);

   logic [swm_pkg::CSR_W-1:0]            window_ff;
   logic [WW-1:0]                        fill_ff;
   logic                                 pend_ff;
   logic                                 out_valid_ff;
   logic [swm_pkg::SAMPLE_W-1:0]         out_data_ff;

   logic [WW-1:0]                        eff_w;
   logic [AGE_W-1:0]                     last_age;
   logic [AGE_W-1:0]                     mid;
   logic                                 full;
   logic                                 step;
   logic                                 out_free;
   logic                                 gives_result;
   logic signed [swm_pkg::SAMPLE_W-1:0]  sample;

   swm_pkg::flags_type                   flags  [MAX_WINDOW];
   logic signed [swm_pkg::SAMPLE_W-1:0]  values [MAX_WINDOW];
   logic [AGE_W-1:0]                     ages   [MAX_WINDOW];
   logic                                 del_below [MAX_WINDOW+1];

   // ---- window size clamp ----
   always_comb begin
      if (window_ff == '0) begin
         eff_w = WW'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         eff_w = WW'(MAX_WINDOW);
      end else begin
         eff_w = WW'(window_ff);
      end
   end

   assign last_age = AGE_W'(eff_w - 1'b1);
   assign mid      = last_age >> 1;
   assign full     = (fill_ff == eff_w);
   assign sample   = req_tdata;

   // ---- handshake ----
   // a median left in the chain must be captured before the chain moves on
   assign out_free     = !out_valid_ff || rsp_tready;
   assign req_tready   = !pend_ff || out_free;
   assign step         = req_tvalid && req_tready;
   assign gives_result = full || ((fill_ff + 1'b1) == eff_w);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---- cell chain ----
   assign del_below[0] = 1'b0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_pkg::flags_type                   lf, rf;
      logic signed [swm_pkg::SAMPLE_W-1:0]  lv, rv;
      logic [AGE_W-1:0]                     la, ra;

      if (i == 0) begin : g_first
         // nothing below: never above the new sample
         assign lf = '{valid: 1'b1, gt: 1'b0};
         assign lv = '0;
         assign la = '0;
      end else begin : g_left
         assign lf = flags[i-1];
         assign lv = values[i-1];
         assign la = ages[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         // past the end: an empty cell
         assign rf = '{valid: 1'b0, gt: 1'b1};
         assign rv = '0;
         assign ra = '0;
      end else begin : g_right
         assign rf = flags[i+1];
         assign rv = values[i+1];
         assign ra = ages[i+1];
      end

      swm_cell #(
         .AGE_W (AGE_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .clear         (csr_we),
         .step          (step),
         .full          (full),
         .last_age      (last_age),
         .sample        (sample),
         .left_flags    (lf),
         .left_value    (lv),
         .left_age      (la),
         .right_flags   (rf),
         .right_value   (rv),
         .right_age     (ra),
         .del_below_in  (del_below[i]),
         .del_below_out (del_below[i+1]),
         .own_flags     (flags[i]),
         .own_value     (values[i]),
         .own_age       (ages[i])
      );
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swm_pkg::CSR_W'(swm_pkg::RESET_WINDOW);
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            window_ff <= csr_wdata;
            fill_ff   <= '0;
         end else if (step && !full) begin
            fill_ff <= fill_ff + 1'b1;
         end

         // median capture from the chain into the output register
         if (pend_ff && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         if (step) begin
            pend_ff <= gives_result && !csr_we;
         end else if (out_free || csr_we) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && out_free) begin
         out_data_ff <= values[mid];
      end
   end

endmodule

// File: hdl/swm_cell.sv
// One cell of the sorted chain: holds a sample and its age, and on each step takes
// its next contents from itself, a neighbor or the incoming sample.
module swm_cell #(
   parameter int AGE_W = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  step,
   input  logic                                  full,
   input  logic [AGE_W-1:0]                      last_age,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample,
   input  swm_pkg::flags_type                    left_flags,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]   left_value,
   input  logic [AGE_W-1:0]                      left_age,
   input  swm_pkg::flags_type                    right_flags,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]   right_value,
   input  logic [AGE_W-1:0]                      right_age,
   input  logic                                  del_below_in,
   output logic                                  del_below_out,
   output swm_pkg::flags_type                    own_flags,
   output logic signed [swm_pkg::SAMPLE_W-1:0]   own_value,
   output logic [AGE_W-1:0]                      own_age
);

   logic                                 valid_ff, valid_in;
   logic signed [swm_pkg::SAMPLE_W-1:0]  value_ff, value_in;
   logic [AGE_W-1:0]                     age_ff, age_in;
   logic                                 leaving;
   swm_pkg::flags_type                   lo_flags, hi_flags;
   logic signed [swm_pkg::SAMPLE_W-1:0]  lo_value, hi_value;
   logic [AGE_W-1:0]                     lo_age, hi_age;

   // this cell's sample is the one leaving the window
   assign leaving       = full && valid_ff && (age_ff == last_age);
   assign del_below_out = del_below_in || leaving;

   assign own_flags.valid = valid_ff;
   assign own_flags.gt    = !valid_ff || (value_ff > sample);
   assign own_value       = value_ff;
   assign own_age         = age_ff;

   always_comb begin
      // lo: what sits at this position once the leaving sample is gone
      if (del_below_out) begin
         lo_flags = right_flags;
         lo_value = right_value;
         lo_age   = right_age;
      end else begin
         lo_flags = own_flags;
         lo_value = value_ff;
         lo_age   = age_ff;
      end
      // hi: what sits one position lower once the leaving sample is gone
      if (del_below_in) begin
         hi_flags = own_flags;
         hi_value = value_ff;
         hi_age   = age_ff;
      end else begin
         hi_flags = left_flags;
         hi_value = left_value;
         hi_age   = left_age;
      end

      if (!lo_flags.gt) begin
         valid_in = lo_flags.valid;
         value_in = lo_value;
         age_in   = lo_age + 1'b1;
      end else if (hi_flags.gt) begin
         valid_in = hi_flags.valid;
         value_in = hi_value;
         age_in   = hi_age + 1'b1;
      end else begin
         valid_in = 1'b1;
         value_in = sample;
         age_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule
